// ----- rtl/xmodem_checksum_receiver_assert.svh -----
// ----------------------------------------------------------------------------
// xmodem checksum receiver assertion macros
// shared property forms for the receiver's concurrent checks
// ----------------------------------------------------------------------------
`ifndef XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH
`define XMODEM_CHECKSUM_RECEIVER_ASSERT_SVH

// same-cycle implication, off during reset
`define XCR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define XCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/xcr_pkg.sv -----
// ----------------------------------------------------------------------------
// xcr_pkg
// constants, phase codes and result record for the xmodem checksum receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcr_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int NAK_W       = 22;

  localparam logic [NAK_W-1:0] NAK_INTERVAL_RST = NAK_W'(2000000);

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CPL_OK = 8'hff;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SEQ    = 3'd1;
  localparam logic [2:0] PH_CPL    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_SUM    = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_ABORT  = 3'd6;

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ABORT = 2'd2;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic [6:0] data_offset;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       block_good;
    logic [7:0] block_seq;
    logic [1:0] status;
  } xcr_result_t;

endpackage

// ----- rtl/xmodem_checksum_receiver.sv -----
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver
// xmodem receiver, 128-byte blocks with 8-bit additive checksum
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_axis    in         tuser: req_type; tdata: rx_byte
//  m_axis    out        tuser: tx_valid, data_valid; tdata: see port comment
//  cfg       in         cfg_wdata: nak_interval
//
//  one transaction per cycle on each side while the output is not stalled; an item
//  waits in the input register and its result, if any, is registered in the output register.
//  a stalled output holds the input register and then s_axis_tready.
//  rst is synchronous; nak_interval returns to 2000000 and the protocol
//  restarts waiting for the first header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmodem_checksum_receiver (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // rx_byte
  input  logic                      s_axis_tuser,   // req_type
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // data_byte[7:0], data_offset[14:8], tx_byte[22:15], block_good[23],
  // block_seq[31:24], status[33:32], zero[39:34]
  output logic [39:0]               m_axis_tdata,
  output logic [1:0]                m_axis_tuser,   // tx_valid[1], data_valid[0]
  input  logic                      cfg_we,
  input  logic [xcr_pkg::NAK_W-1:0] cfg_wdata
);
  import xcr_pkg::*;

  logic             in_valid;
  logic             in_type;
  logic [7:0]       in_byte;
  logic             go;
  logic             res_valid;
  xcr_result_t      res;
  xcr_result_t      out_res;
  logic [NAK_W-1:0] nak_interval;

  assign go            = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      nak_interval <= NAK_INTERVAL_RST;
    end else if (cfg_we) begin
      nak_interval <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_type <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  xcr_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .req_type     (in_type),
    .rx_byte      (in_byte),
    .nak_interval (nak_interval),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (go && res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tuser = {out_res.tx_valid, out_res.data_valid};
  assign m_axis_tdata = {6'd0, out_res.status, out_res.block_seq, out_res.block_good,
                         out_res.tx_byte, out_res.data_offset, out_res.data_byte};

endmodule

// ----- rtl/xcr_fsm.sv -----
// ----------------------------------------------------------------------------
// xcr_fsm
// protocol state and per-item update: header, sequence, complement, data, sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xmodem_checksum_receiver_assert.svh"

module xcr_fsm (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic                     req_type,
  input  logic [7:0]               rx_byte,
  input  logic [xcr_pkg::NAK_W-1:0] nak_interval,
  output logic                     res_valid,
  output xcr_pkg::xcr_result_t     res
);
  import xcr_pkg::*;

  logic [2:0]       phase, phase_next;
  logic             started, started_next;
  logic [7:0]       expected_seq, expected_seq_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [6:0]       byte_index, byte_index_next;
  logic [NAK_W-1:0] tick_count, tick_count_next;
  logic [NAK_W:0]   tick_sum;

  assign tick_sum = {1'b0, tick_count} + (NAK_W+1)'(1);

  always_comb begin
    phase_next        = phase;
    started_next      = started;
    expected_seq_next = expected_seq;
    running_sum_next  = running_sum;
    byte_index_next   = byte_index;
    tick_count_next   = tick_count;
    res_valid         = 1'b0;
    res               = '0;
    res.status        = ST_RUN;

    if (go && phase != PH_DONE && phase != PH_ABORT) begin
      if (req_type == REQ_TICK) begin
        if (phase == PH_HEADER && !started) begin
          if (tick_sum >= {1'b0, nak_interval}) begin
            tick_count_next = '0;
            res_valid       = 1'b1;
            res.tx_valid    = 1'b1;
            res.tx_byte     = CH_NAK;
          end else begin
            tick_count_next = tick_sum[NAK_W-1:0];
          end
        end
      end else begin
        unique case (phase)
          PH_HEADER: begin
            tick_count_next = '0;
            if (rx_byte == CH_EOT) begin
              phase_next   = PH_DONE;
              res_valid    = 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = CH_ACK;
              res.status   = ST_DONE;
            end else if (rx_byte == CH_CAN) begin
              phase_next = PH_ABORT;
              res_valid  = 1'b1;
              res.status = ST_ABORT;
            end else if (rx_byte == CH_SOH) begin
              started_next = 1'b1;
              phase_next   = PH_SEQ;
            end else if (started) begin
              // stray byte once the transfer is running
              phase_next = PH_ABORT;
              res_valid  = 1'b1;
              res.status = ST_ABORT;
            end
          end
          PH_SEQ: begin
            if (rx_byte != expected_seq) begin
              phase_next   = PH_HEADER;
              res_valid    = 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = CH_NAK;
            end else begin
              phase_next = PH_CPL;
            end
          end
          PH_CPL: begin
            if ((expected_seq ^ rx_byte) != CPL_OK) begin
              phase_next   = PH_HEADER;
              res_valid    = 1'b1;
              res.tx_valid = 1'b1;
              res.tx_byte  = CH_NAK;
            end else begin
              running_sum_next = '0;
              byte_index_next  = '0;
              phase_next       = PH_DATA;
            end
          end
          PH_DATA: begin
            running_sum_next = running_sum + rx_byte;
            if (byte_index == 7'(BLOCK_BYTES - 1)) begin
              byte_index_next = '0;
              phase_next      = PH_SUM;
            end else begin
              byte_index_next = byte_index + 7'd1;
            end
            res_valid       = 1'b1;
            res.data_valid  = 1'b1;
            res.data_byte   = rx_byte;
            res.data_offset = byte_index;
          end
          PH_SUM: begin
            phase_next   = PH_HEADER;
            res_valid    = 1'b1;
            res.tx_valid = 1'b1;
            if (running_sum != rx_byte) begin
              res.tx_byte = CH_NAK;
            end else begin
              res.tx_byte       = CH_ACK;
              res.block_good    = 1'b1;
              res.block_seq     = expected_seq;
              expected_seq_next = expected_seq + 8'd1;
            end
          end
          default: begin
            phase_next = PH_ABORT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      started      <= 1'b0;
      expected_seq <= 8'd1;
      running_sum  <= '0;
      byte_index   <= '0;
      tick_count   <= '0;
    end else begin
      phase        <= phase_next;
      started      <= started_next;
      expected_seq <= expected_seq_next;
      running_sum  <= running_sum_next;
      byte_index   <= byte_index_next;
      tick_count   <= tick_count_next;
    end
  end

  `XCR_ASSERT_NEXT(a_done_sticks, clk, rst, phase == PH_DONE, phase == PH_DONE)
  `XCR_ASSERT_NEXT(a_abort_sticks, clk, rst, phase == PH_ABORT, phase == PH_ABORT)
  `XCR_ASSERT_NEXT(a_started_sticks, clk, rst, started, started)
  `XCR_ASSERT_NOW(a_one_kind, clk, rst, res_valid && res.data_valid,
                  !res.tx_valid && !res.block_good)
  `XCR_ASSERT_NEXT(a_seq_advance, clk, rst, res_valid && res.block_good,
                   expected_seq == $past(expected_seq) + 8'd1)

endmodule
